### sv/fgac_pkg.sv
`timescale 1ns / 1ps
// fgac_pkg: widths, register indexes, codes and stage types of the fat geometry unit
// depends on nothing; imported by the top level

package fgac_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_BYTES_PER_SECTOR    = 3'd0;
    localparam logic [2:0] REG_SECTORS_PER_CLUSTER = 3'd1;
    localparam logic [2:0] REG_RESERVED_SECTORS    = 3'd2;
    localparam logic [2:0] REG_FAT_COPIES          = 3'd3;
    localparam logic [2:0] REG_ROOT_ENTRIES        = 3'd4;
    localparam logic [2:0] REG_FAT_SIZE_SECTORS    = 3'd5;
    localparam logic [2:0] REG_TOTAL_SECTORS       = 3'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // fat kind codes
    localparam logic [1:0] KIND_FAT12 = 2'd0;
    localparam logic [1:0] KIND_FAT16 = 2'd1;
    localparam logic [1:0] KIND_FAT32 = 2'd2;

    localparam logic [31:0] FAT12_LIMIT = 32'd4085;
    localparam logic [31:0] FAT16_LIMIT = 32'd65525;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 144;

    // per-item entry offset divider: 30 bit dividend, 13 bit sector size
    localparam int DIV_NUM_W      = 30;
    localparam int DIV_DEN_W      = 13;
    localparam int DIV_STAGE_BITS = 2;
    localparam int DIV_STAGES     = DIV_NUM_W / DIV_STAGE_BITS;

    typedef struct packed {
        logic [DIV_NUM_W-1:0] num;    // dividend bits still to shift in
        logic [DIV_DEN_W-1:0] rem;    // partial remainder
        logic [DIV_NUM_W-1:0] quo;    // quotient bits so far
        logic [31:0]          acc_a;  // cluster sector path
        logic [31:0]          acc_b;  // fat copy base path
        logic                 oor;    // cluster out of range
    } pipe_t;

    typedef struct packed {
        logic        out_of_range;
        logic [11:0] entry_byte_offset;
        logic [31:0] fat_entry_sector;
        logic [31:0] cluster_sector;
    } result_t;

endpackage

### sv/fat_geometry_address_calc_unit.sv
`timescale 1ns / 1ps
// fat_geometry_address_calc_unit: fat volume geometry and cluster address pipeline
// depends on fgac_pkg
//
// an accepted item enters divider stage 0 at the accepting edge, crosses the other 14
// of the 15 entry offset divider stages (two quotient bits per stage) and then the
// output register
// throughput: one item per cycle; m_tready low while a result is held stalls the whole
// pipeline in place; after reset and after every configuration write a geometry pass
// runs on a shared one-bit-per-cycle divider; s_tready stays low until it finishes
// reset: aresetn synchronous, active low; config registers return to their boot defaults

module fat_geometry_address_calc_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [27:0] cluster_number, [30:28] fat_copy, [31] zero
    input  logic [fgac_pkg::S_TDATA_W-1:0]  s_tdata,
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] cluster_sector, [63:32] fat_entry_sector, [75:64] entry_byte_offset,
    // [107:76] first_data_sector, [139:108] cluster_count, [141:140] fat_kind,
    // [142] cluster_out_of_range, [143] geometry_bad
    output logic [fgac_pkg::M_TDATA_W-1:0]  m_tdata,
    // configuration writes
    input  logic                            cfg_we,
    input  logic [fgac_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fgac_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    import fgac_pkg::*;

    // ---------------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------------
    logic [12:0] bps_reg;
    logic [7:0]  spc_reg;
    logic [15:0] reserved_reg;
    logic [2:0]  fat_copies_reg;
    logic [15:0] root_entries_reg;
    logic [31:0] fat_size_reg;
    logic [31:0] total_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bps_reg          <= 13'd512;
            spc_reg          <= 8'd1;
            reserved_reg     <= 16'd32;
            fat_copies_reg   <= 3'd2;
            root_entries_reg <= 16'd0;
            fat_size_reg     <= 32'd1;
            total_reg        <= 32'd0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_BYTES_PER_SECTOR:    bps_reg          <= cfg_wdata[12:0];
                REG_SECTORS_PER_CLUSTER: spc_reg          <= cfg_wdata[7:0];
                REG_RESERVED_SECTORS:    reserved_reg     <= cfg_wdata[15:0];
                REG_FAT_COPIES:          fat_copies_reg   <= cfg_wdata[2:0];
                REG_ROOT_ENTRIES:        root_entries_reg <= cfg_wdata[15:0];
                REG_FAT_SIZE_SECTORS:    fat_size_reg     <= cfg_wdata;
                REG_TOTAL_SECTORS:       total_reg        <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // geometry sequencer: root dir sectors, overhead, cluster count, kind
    // one shared restoring divider, one quotient bit per cycle
    // ---------------------------------------------------------------------
    typedef enum logic [2:0] {
        G_ROOT, G_ROOT_DIV, G_OVH, G_SUB, G_CNT_DIV, G_KIND, G_READY
    } geo_state_t;

    geo_state_t  geo_state_reg, geo_state_next;
    logic [31:0] gnum_reg, gnum_next;
    logic [12:0] grem_reg, grem_next;
    logic [31:0] gquo_reg, gquo_next;
    logic [12:0] gden_reg, gden_next;
    logic [4:0]  gcnt_reg, gcnt_next;
    logic [21:0] root_sec_reg, root_sec_next;
    logic [35:0] ovh_reg, ovh_next;
    logic        bad_reg, bad_next;
    logic [31:0] count_reg, count_next;
    logic [1:0]  kind_reg, kind_next;

    logic [13:0] gpart;
    logic [13:0] gpart_sub;
    logic        gge;
    logic [12:0] gstep_rem;
    logic [31:0] gstep_quo;

    // one divider step on the current registers
    always_comb begin
        gpart     = {grem_reg, gnum_reg[31]};
        gge       = gpart >= {1'b0, gden_reg};
        gpart_sub = gpart - {1'b0, gden_reg};
        gstep_rem = gge ? gpart_sub[12:0] : gpart[12:0];
        gstep_quo = {gquo_reg[30:0], gge};
    end

    always_comb begin
        geo_state_next = geo_state_reg;
        gnum_next      = gnum_reg;
        grem_next      = grem_reg;
        gquo_next      = gquo_reg;
        gden_next      = gden_reg;
        gcnt_next      = gcnt_reg;
        root_sec_next  = root_sec_reg;
        ovh_next       = ovh_reg;
        bad_next       = bad_reg;
        count_next     = count_reg;
        kind_next      = kind_reg;
        case (geo_state_reg)
            G_ROOT: begin
                // ceil(root_entries * 32 / bytes_per_sector)
                gnum_next = 32'({root_entries_reg, 5'b0}) + 32'(bps_reg)
                          - 32'(bps_reg != 13'd0);
                gden_next = bps_reg;
                grem_next = '0;
                gquo_next = '0;
                gcnt_next = '0;
                geo_state_next = G_ROOT_DIV;
            end
            G_ROOT_DIV: begin
                gnum_next = {gnum_reg[30:0], 1'b0};
                grem_next = gstep_rem;
                gquo_next = gstep_quo;
                gcnt_next = gcnt_reg + 5'd1;
                if (gcnt_reg == 5'd31) begin
                    root_sec_next  = (gden_reg == 13'd0) ? 22'd0 : gstep_quo[21:0];
                    geo_state_next = G_OVH;
                end
            end
            G_OVH: begin
                // exact overhead, no wrap
                ovh_next = 36'(reserved_reg) + 36'(fat_copies_reg) * 36'(fat_size_reg)
                         + 36'(root_sec_reg);
                geo_state_next = G_SUB;
            end
            G_SUB: begin
                bad_next  = ovh_reg > 36'(total_reg);
                gnum_next = (ovh_reg > 36'(total_reg)) ? 32'd0 : total_reg - ovh_reg[31:0];
                gden_next = 13'(spc_reg);
                grem_next = '0;
                gquo_next = '0;
                gcnt_next = '0;
                geo_state_next = G_CNT_DIV;
            end
            G_CNT_DIV: begin
                gnum_next = {gnum_reg[30:0], 1'b0};
                grem_next = gstep_rem;
                gquo_next = gstep_quo;
                gcnt_next = gcnt_reg + 5'd1;
                if (gcnt_reg == 5'd31) begin
                    count_next = (bad_reg || gden_reg == 13'd0) ? 32'd0 : gstep_quo;
                    geo_state_next = G_KIND;
                end
            end
            G_KIND: begin
                if (count_reg < FAT12_LIMIT) begin
                    kind_next = KIND_FAT12;
                end else if (count_reg < FAT16_LIMIT) begin
                    kind_next = KIND_FAT16;
                end else begin
                    kind_next = KIND_FAT32;
                end
                geo_state_next = G_READY;
            end
            G_READY: ;
            default: geo_state_next = G_ROOT;
        endcase
        // any register write restarts the pass
        if (cfg_we) begin
            geo_state_next = G_ROOT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            geo_state_reg <= G_ROOT;
            root_sec_reg  <= '0;
            ovh_reg       <= '0;
            bad_reg       <= 1'b0;
            count_reg     <= '0;
            kind_reg      <= KIND_FAT12;
        end else begin
            geo_state_reg <= geo_state_next;
            root_sec_reg  <= root_sec_next;
            ovh_reg       <= ovh_next;
            bad_reg       <= bad_next;
            count_reg     <= count_next;
            kind_reg      <= kind_next;
        end
        gnum_reg <= gnum_next;
        grem_reg <= grem_next;
        gquo_reg <= gquo_next;
        gden_reg <= gden_next;
        gcnt_reg <= gcnt_next;
    end

    logic geo_ready;
    assign geo_ready = (geo_state_reg == G_READY);

    logic [31:0] first_data;
    assign first_data = ovh_reg[31:0];

    // ---------------------------------------------------------------------
    // item pipeline: 15 divider stages, then the output register
    // stage 0 subtracts, stage 1 multiplies, stage 2 adds the bases
    // ---------------------------------------------------------------------
    function automatic pipe_t div_step(pipe_t p, logic [DIV_DEN_W-1:0] d);
        logic [DIV_DEN_W:0] part;
        pipe_t              o;
        o = p;
        for (int b = 0; b < DIV_STAGE_BITS; b++) begin
            part  = {o.rem, o.num[DIV_NUM_W-1]};
            o.num = {o.num[DIV_NUM_W-2:0], 1'b0};
            if (part >= {1'b0, d}) begin
                part  = part - {1'b0, d};
                o.quo = {o.quo[DIV_NUM_W-2:0], 1'b1};
            end else begin
                o.quo = {o.quo[DIV_NUM_W-2:0], 1'b0};
            end
            o.rem = part[DIV_DEN_W-1:0];
        end
        return o;
    endfunction

    logic                  adv;
    logic                  accept;
    logic [27:0]           in_cluster;
    logic [2:0]            in_copy;
    pipe_t                 entry;
    pipe_t                 pipe_reg  [DIV_STAGES];
    pipe_t                 pipe_next [DIV_STAGES];
    logic [DIV_STAGES-1:0] vld_reg;
    logic [DIV_STAGES-1:0] vld_next;
    result_t               res_reg, res_next;
    logic                  out_valid_reg, out_valid_next;

    assign in_cluster = s_tdata[27:0];
    assign in_copy    = s_tdata[30:28];

    // the whole pipeline moves unless the output item is held
    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv && geo_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        entry.num   = {in_cluster, 2'b00};
        entry.rem   = '0;
        entry.quo   = '0;
        entry.acc_a = 32'(in_cluster) - 32'd2;
        entry.acc_b = 32'(in_copy - 3'd1);
        entry.oor   = (in_cluster < 28'd2) || (32'(in_cluster) > count_reg);

        pipe_next[0] = div_step(entry, bps_reg);
        vld_next[0]  = accept;
        for (int k = 1; k < DIV_STAGES; k++) begin
            pipe_next[k] = div_step(pipe_reg[k-1], bps_reg);
            vld_next[k]  = vld_reg[k-1];
            if (k == 1) begin
                pipe_next[k].acc_a = pipe_reg[k-1].acc_a * 32'(spc_reg);
                pipe_next[k].acc_b = 32'(pipe_reg[k-1].acc_b[2:0]) * fat_size_reg;
            end else if (k == 2) begin
                pipe_next[k].acc_a = pipe_reg[k-1].acc_a + first_data;
                pipe_next[k].acc_b = pipe_reg[k-1].acc_b + 32'(reserved_reg);
            end
        end

        // last stage: a zero sector size gives quotient and remainder zero
        res_next.cluster_sector    = pipe_reg[DIV_STAGES-1].acc_a;
        res_next.fat_entry_sector  = pipe_reg[DIV_STAGES-1].acc_b
            + ((bps_reg == '0) ? 32'd0 : 32'(pipe_reg[DIV_STAGES-1].quo));
        res_next.entry_byte_offset = (bps_reg == '0) ? 12'd0
                                   : pipe_reg[DIV_STAGES-1].rem[11:0];
        res_next.out_of_range      = pipe_reg[DIV_STAGES-1].oor;
        out_valid_next             = vld_reg[DIV_STAGES-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
        end
        if (adv) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                pipe_reg[k] <= pipe_next[k];
            end
            res_reg <= res_next;
        end
    end

    // geometry fields are constant in flight only if the user writes no register; not enforced
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {bad_reg, res_reg.out_of_range, kind_reg, count_reg, first_data,
                       res_reg.entry_byte_offset, res_reg.fat_entry_sector,
                       res_reg.cluster_sector};

endmodule

### sv/fgac_checker.sv
`timescale 1ns / 1ps
// fgac_checker: port level checks of fat_geometry_address_calc_unit, and its bind
// depends on fgac_pkg

module fgac_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [fgac_pkg::S_TDATA_W-1:0]   s_tdata,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [fgac_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                             cfg_we
);

    import fgac_pkg::*;

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // geometry pass runs after reset, no item taken
    a_reset_busy: assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("item accepted during geometry pass after reset");

    // a register write restarts the geometry pass
    a_cfg_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_tready)
        else $error("item accepted right after a register write");

    // waiting input item keeps its payload
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("waiting input item changed");

    // held result keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind fat_geometry_address_calc_unit fgac_checker u_fgac_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we)
);

### verif/fat_lookup_checker.sv
`timescale 1ns / 1ps
// fat_lookup_checker: follows the configuration writes, predicts every cluster lookup and
// compares the result items field by field; depends on fgac_pkg

module fat_lookup_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [fgac_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [fgac_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             cfg_we,
    input  logic [fgac_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fgac_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                               mismatches,
    output int                               lookups_pending,
    output int                               results_compared
);
    import fgac_pkg::*;

    localparam logic [63:0] DIR_ENTRY_BYTES = 64'd32;
    localparam logic [63:0] FAT_ENTRY_BYTES = 64'd4;
    localparam logic [63:0] FIRST_CLUSTER   = 64'd2;

    // same layout as m_tdata, lowest field last
    typedef struct packed {
        logic        geometry_bad;
        logic        cluster_out_of_range;
        logic [1:0]  fat_kind;
        logic [31:0] cluster_count;
        logic [31:0] first_data_sector;
        logic [11:0] entry_byte_offset;
        logic [31:0] fat_entry_sector;
        logic [31:0] cluster_sector;
    } fat_lookup_t;

    logic [12:0] bytes_per_sector;
    logic [7:0]  sectors_per_cluster;
    logic [15:0] reserved_sectors;
    logic [2:0]  fat_copies;
    logic [15:0] root_entries;
    logic [31:0] fat_size_sectors;
    logic [31:0] total_sectors;

    fat_lookup_t lookups_due [$];

    function automatic fat_lookup_t locate_cluster(input logic [27:0] cluster,
                                                   input logic [2:0] copy_sel);
        fat_lookup_t r;
        logic [63:0] sec_size, root_secs, overhead, clusters, byte_pos;
        logic [2:0]  copy_idx;
        logic        bad;
        sec_size  = 64'(bytes_per_sector);
        root_secs = (sec_size == 0) ? 64'd0 :
                    (64'(root_entries) * DIR_ENTRY_BYTES + sec_size - 64'd1) / sec_size;
        // exact sum, no wrap in 64 bits
        overhead  = 64'(reserved_sectors) + 64'(fat_copies) * 64'(fat_size_sectors)
                    + root_secs;
        bad       = overhead > 64'(total_sectors);
        clusters  = (bad || sectors_per_cluster == 0) ? 64'd0 :
                    (64'(total_sectors) - overhead) / 64'(sectors_per_cluster);
        byte_pos  = 64'(cluster) * FAT_ENTRY_BYTES;
        copy_idx  = copy_sel - 3'd1;   // copy zero wraps to index seven

        r.cluster_sector       = 32'((64'(cluster) - FIRST_CLUSTER) * 64'(sectors_per_cluster)
                                     + overhead);
        r.fat_entry_sector     = 32'(64'(reserved_sectors)
                                     + ((sec_size == 0) ? 64'd0 : byte_pos / sec_size)
                                     + 64'(copy_idx) * 64'(fat_size_sectors));
        r.entry_byte_offset    = 12'((sec_size == 0) ? 64'd0 : byte_pos % sec_size);
        r.first_data_sector    = 32'(overhead);
        r.cluster_count        = 32'(clusters);
        r.fat_kind             = (clusters < 64'(FAT12_LIMIT)) ? KIND_FAT12 :
                                 (clusters < 64'(FAT16_LIMIT)) ? KIND_FAT16 : KIND_FAT32;
        r.cluster_out_of_range = (64'(cluster) < FIRST_CLUSTER) || (64'(cluster) > clusters);
        r.geometry_bad         = bad;
        return r;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want, got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        fat_lookup_t got, want;
        if (!aresetn) begin
            bytes_per_sector    = 13'd512;
            sectors_per_cluster = 8'd1;
            reserved_sectors    = 16'd32;
            fat_copies          = 3'd2;
            root_entries        = 16'd0;
            fat_size_sectors    = 32'd1;
            total_sectors       = 32'd0;
            lookups_due.delete();
            mismatches          = 0;
            results_compared    = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                lookups_due.push_back(locate_cluster(s_tdata[27:0], s_tdata[30:28]));
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_BYTES_PER_SECTOR:    bytes_per_sector    = cfg_wdata[12:0];
                    REG_SECTORS_PER_CLUSTER: sectors_per_cluster = cfg_wdata[7:0];
                    REG_RESERVED_SECTORS:    reserved_sectors    = cfg_wdata[15:0];
                    REG_FAT_COPIES:          fat_copies          = cfg_wdata[2:0];
                    REG_ROOT_ENTRIES:        root_entries        = cfg_wdata[15:0];
                    REG_FAT_SIZE_SECTORS:    fat_size_sectors    = cfg_wdata;
                    REG_TOTAL_SECTORS:       total_sectors       = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (lookups_due.size() == 0) begin
                    $error("result item with no lookup pending: 0x%0h", m_tdata);
                    mismatches++;
                end else begin
                    want = lookups_due.pop_front();
                    check_field("cluster_sector", want.cluster_sector, got.cluster_sector);
                    check_field("fat_entry_sector", want.fat_entry_sector,
                                got.fat_entry_sector);
                    check_field("entry_byte_offset", 32'(want.entry_byte_offset),
                                32'(got.entry_byte_offset));
                    check_field("first_data_sector", want.first_data_sector,
                                got.first_data_sector);
                    check_field("cluster_count", want.cluster_count, got.cluster_count);
                    check_field("fat_kind", 32'(want.fat_kind), 32'(got.fat_kind));
                    check_field("cluster_out_of_range", 32'(want.cluster_out_of_range),
                                32'(got.cluster_out_of_range));
                    check_field("geometry_bad", 32'(want.geometry_bad),
                                32'(got.geometry_bad));
                    results_compared++;
                end
            end
        end
        lookups_pending = lookups_due.size();
    end

endmodule

### verif/fat_geometry_address_calc_unit_tb.sv
`timescale 1ns / 1ps
// fat_geometry_address_calc_unit_tb: drives volume geometries and cluster lookups into the
// address unit and gives the verdict; depends on fgac_pkg, the unit and fat_lookup_checker

module fat_geometry_address_calc_unit_tb;
    import fgac_pkg::*;

    // every input known from time zero
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    int mismatches, lookups_pending, results_compared;
    int lookups_sent = 0;
    int geometries   = 1;   // reset defaults count as the first one

    // per phase: random gaps on the source, random stalls on the sink
    bit src_busy  = 1'b0;
    bit sink_busy = 1'b0;

    fat_geometry_address_calc_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    fat_lookup_checker checker_i (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .mismatches       (mismatches),
        .lookups_pending  (lookups_pending),
        .results_compared (results_compared)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // single reset at the start of the run
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #2000000;
        $display("[fat_geometry_address_calc_unit] ERROR");
        $finish;
    end

    // result side: random stall before each item, none in quiet phases
    initial begin
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = sink_busy ? $urandom_range(0, 15) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // one lookup; s_tvalid stays high into the next item when there is no gap
    task automatic send_lookup(input logic [27:0] cluster, input logic [2:0] copy_sel);
        int gap;
        gap = src_busy ? $urandom_range(0, 15) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, copy_sel, cluster};
        do @(posedge aclk); while (!s_tready);
        lookups_sent++;
    endtask

    // wait until every lookup has come back
    task automatic drain_lookups();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (lookups_pending != 0) @(posedge aclk);
        repeat (24) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
    endtask

    // writes all seven registers back to back, after draining the lookups in flight
    task automatic load_geometry(input logic [31:0] bps, spc, res, copies, root, fsz, total);
        drain_lookups();
        write_reg(REG_BYTES_PER_SECTOR, bps);
        write_reg(REG_SECTORS_PER_CLUSTER, spc);
        write_reg(REG_RESERVED_SECTORS, res);
        write_reg(REG_FAT_COPIES, copies);
        write_reg(REG_ROOT_ENTRIES, root);
        write_reg(REG_FAT_SIZE_SECTORS, fsz);
        write_reg(REG_TOTAL_SECTORS, total);
        cfg_we <= 1'b0;
        geometries++;
        src_busy  = ($urandom_range(0, 3) != 0);
        sink_busy = ($urandom_range(0, 3) != 0);
    endtask

    initial begin
        logic [31:0] bps, spc, res, copies, root, fsz, total, overhead, clusters;
        logic [27:0] cluster;
        logic [2:0]  copy_sel;
        bit          count_known;
        int          band;
        wait (aresetn);
        @(posedge aclk);

        // reset defaults: zero total sectors, so the geometry is bad
        send_lookup(28'd0, 3'd0);
        send_lookup(28'd1, 3'd1);
        send_lookup(28'h0FFFFFFF, 3'd7);

        // floppy style fat12, 2847 clusters; last valid, one past, sector edge, extra copy
        load_geometry(512, 1, 1, 2, 224, 9, 2880);
        send_lookup(28'd2, 3'd1);
        send_lookup(28'd2847, 3'd2);
        send_lookup(28'd2848, 3'd3);
        send_lookup(28'd127, 3'd4);
        send_lookup(28'd128, 3'd5);

        // zero divisors everywhere, no fat copies
        load_geometry(0, 0, 0, 0, 0, 0, 5);
        send_lookup(28'd2, 3'd1);
        send_lookup(28'd5, 3'd2);

        // largest odd sector size: offsets above 4095 get truncated
        load_geometry(8191, 3, 1, 1, 100, 10, 100000);
        send_lookup(28'h0FFFFFFF, 3'd1);
        send_lookup(28'd1500, 3'd1);
        send_lookup(28'd2047, 3'd6);

        // every register at its top value, overhead far beyond the volume
        load_geometry(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                      32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_lookup(28'h0FFFFFFF, 3'd0);
        send_lookup(28'd2, 3'd7);

        // large fat32 volume; high clusters wrap the cluster sector
        load_geometry(512, 128, 32, 2, 0, 32'h00100000, 32'hFFFFFFFF);
        send_lookup(28'h0FFFFFFF, 3'd4);
        send_lookup(28'd65525, 3'd3);
        send_lookup(28'd3, 3'd1);

        // random geometries, mostly well formed volumes in one of the three fat bands
        for (int phase = 0; phase < 9; phase++) begin
            if ($urandom_range(0, 9) < 7) begin
                bps      = 32'd512 << $urandom_range(0, 3);
                spc      = 32'd1 << $urandom_range(0, 7);
                res      = $urandom_range(1, 64);
                copies   = $urandom_range(1, 4);
                root     = $urandom_range(0, 1) ? 16 * $urandom_range(0, 64) : 0;
                fsz      = $urandom_range(1, 5000);
                overhead = res + copies * fsz + (root * 32 + bps - 1) / bps;
                band     = $urandom_range(0, 2);
                // a quarter of the volumes sit right at a fat type limit
                case (band)
                    0: clusters = ($urandom_range(0, 3) == 0) ? 32'd4084
                                                                : $urandom_range(2, 4084);
                    1: clusters = ($urandom_range(0, 3) == 0)
                                  ? ($urandom_range(0, 1) ? 32'd4085 : 32'd65524)
                                  : $urandom_range(4085, 65524);
                    default: clusters = ($urandom_range(0, 3) == 0) ? 32'd65525
                                        : $urandom_range(65525, 32'h00FFFFFF);
                endcase
                total       = overhead + clusters * spc + $urandom_range(0, spc - 1);
                count_known = 1'b1;
            end else begin
                // raw register values, upper write bits included
                bps         = $urandom;
                spc         = $urandom;
                res         = $urandom;
                copies      = $urandom;
                root        = $urandom;
                fsz         = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4096);
                total       = $urandom;
                clusters    = 0;
                count_known = 1'b0;
            end
            load_geometry(bps, spc, res, copies, root, fsz, total);
            if (!count_known || copies[2:0] == 0) copies = 4;

            for (int i = 0; i < 50; i++) begin
                band = $urandom_range(0, 9);
                if (count_known && band < 5) begin
                    cluster = 28'($urandom_range(2, clusters));
                end else if (count_known && band < 7) begin
                    case ($urandom_range(0, 5))
                        0: cluster = 28'd0;
                        1: cluster = 28'd1;
                        2: cluster = 28'd2;
                        3: cluster = 28'(clusters - 32'd1);
                        4: cluster = 28'(clusters);
                        default: cluster = 28'(clusters + 32'd1);
                    endcase
                end else if (band < 8) begin
                    cluster = 28'($urandom_range(0, 16));
                end else begin
                    cluster = 28'($urandom);
                end
                copy_sel = ($urandom_range(0, 4) != 0) ? 3'($urandom_range(1, copies[2:0]))
                                                       : 3'($urandom);
                send_lookup(cluster, copy_sel);
            end
        end

        drain_lookups();
        $display("run covered %0d cluster lookups (%0d results compared) over %0d geometries",
                 lookups_sent, results_compared, geometries);
        $display("fat12/16/32 limits, zero divisors, odd sector sizes, bad and wrapping volumes");
        if (mismatches == 0) begin
            $display("[fat_geometry_address_calc_unit] OK");
        end else begin
            $display("[fat_geometry_address_calc_unit] ERROR");
        end
        $finish;
    end

endmodule

### sim.f
sv/fgac_pkg.sv
sv/fat_geometry_address_calc_unit.sv
sv/fgac_checker.sv
verif/fat_lookup_checker.sv
verif/fat_geometry_address_calc_unit_tb.sv
